/* design/dual_mode_frame_receiver_macros.svh */
// assertion macros shared by the frame receiver checker
`ifndef DUAL_MODE_FRAME_RECEIVER_MACROS_SVH
`define DUAL_MODE_FRAME_RECEIVER_MACROS_SVH

// property checked on every clock edge outside reset
`define DMFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define DMFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dmfr_pkg.sv */
// shared types and constants for the dual mode frame receiver
package dmfr_pkg;

  localparam int BUF_DEPTH_DEF = 256;

  localparam int DATA_W      = 8;
  localparam int COUNT_OUT_W = 9;
  localparam int LEN_W       = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DATA_W-1:0] BINARY_MARK = 8'hA0;
  localparam logic [DATA_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF     = 8'h0A;

  // binary header: length bytes sit at index 2 and 3
  localparam int LEN_HI_IDX    = 2;
  localparam int LEN_MIN_COUNT = 4;
  localparam int LEN_ADJ       = 7;

  typedef enum logic [IN_TUSER_W-1:0] {
    REQ_BYTE    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] frame_count;
    logic                   frame_done;
    logic                   cr_seen;
    logic                   binary_mode;
    logic                   restarted;
  } status_t;

endpackage

/* design/dmfr_buffer.sv */
// frame buffer memory, one write port and one registered read port
module dmfr_buffer #(
  parameter int DEPTH = dmfr_pkg::BUF_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [dmfr_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [dmfr_pkg::DATA_W-1:0] rd_data
);

  logic [dmfr_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/dmfr_ctrl.sv */
// frame state registers and per-item next-state logic
module dmfr_ctrl #(
  parameter int BUF_DEPTH = dmfr_pkg::BUF_DEPTH_DEF,
  parameter int AW        = $clog2(BUF_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  dmfr_pkg::req_t              req,
  input  logic [dmfr_pkg::DATA_W-1:0] rx_byte,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [dmfr_pkg::DATA_W-1:0] wr_data,
  output dmfr_pkg::status_t           status
);

  localparam int CW  = $clog2(BUF_DEPTH + 1);
  localparam int LW  = dmfr_pkg::LEN_W;
  localparam int FCW = dmfr_pkg::COUNT_OUT_W;

  logic [CW-1:0]               count, count_next;
  logic                        done, done_next;
  logic                        cr, cr_next;
  logic                        binary, binary_next;
  logic [LW-1:0]               len, len_next;
  logic [dmfr_pkg::DATA_W-1:0] len_hi, len_hi_next;

  logic [CW-1:0] c0, cnt_inc;
  logic          bin0, cr0, bin1, cr1, in_buf, restart;
  logic [LW-1:0] len_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done   <= 1'b0;
      cr     <= 1'b0;
      binary <= 1'b0;
      len    <= '0;
      len_hi <= '0;
    end else begin
      count  <= count_next;
      done   <= done_next;
      cr     <= cr_next;
      binary <= binary_next;
      len    <= len_next;
      len_hi <= len_hi_next;
    end
  end

  assign wr_data = rx_byte;

  always_comb begin
    // a byte after a finished frame starts from an empty frame
    c0      = done ? '0 : count;
    bin0    = done ? 1'b0 : binary;
    cr0     = done ? 1'b0 : cr;
    bin1    = (c0 == '0) ? (rx_byte == dmfr_pkg::BINARY_MARK) : bin0;
    cr1     = (c0 == '0) ? 1'b0 : cr0;
    cnt_inc = c0 + CW'(1);
    in_buf  = 32'(c0) < BUF_DEPTH;
    len_calc = (cnt_inc == CW'(dmfr_pkg::LEN_MIN_COUNT)) ?
               (LW'({len_hi, rx_byte}) + LW'(dmfr_pkg::LEN_ADJ)) : len;

    count_next  = count;
    done_next   = done;
    cr_next     = cr;
    binary_next = binary;
    len_next    = len;
    len_hi_next = len_hi;
    restart     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = AW'(c0);

    if (fire) begin
      unique case (req)
        dmfr_pkg::REQ_BYTE: begin
          count_next  = c0;
          done_next   = 1'b0;
          cr_next     = cr1;
          binary_next = bin1;
          if (bin1) begin
            wr_en      = in_buf;
            count_next = cnt_inc;
            if (c0 == CW'(dmfr_pkg::LEN_HI_IDX)) begin
              len_hi_next = rx_byte;
            end
            if (cnt_inc >= CW'(dmfr_pkg::LEN_MIN_COUNT)) begin
              len_next = len_calc;
              if (32'(cnt_inc) >= BUF_DEPTH) begin
                restart = 1'b1;
              end else if (LW'(cnt_inc) == len_calc) begin
                done_next = 1'b1;
              end
            end
          end else if (cr1) begin
            if (rx_byte != dmfr_pkg::CHAR_LF) begin
              restart = 1'b1;
            end else begin
              // lf is stored but not counted
              wr_en     = in_buf;
              cr_next   = 1'b0;
              done_next = 1'b1;
            end
          end else begin
            wr_en      = in_buf;
            count_next = cnt_inc;
            if (rx_byte == dmfr_pkg::CHAR_CR) begin
              cr_next = 1'b1;
            end else if (32'(cnt_inc) >= BUF_DEPTH) begin
              restart = 1'b1;
            end
          end
          if (restart) begin
            count_next  = '0;
            done_next   = 1'b0;
            cr_next     = 1'b0;
            binary_next = 1'b0;
          end
        end
        dmfr_pkg::REQ_RELEASE: begin
          count_next  = '0;
          done_next   = 1'b0;
          cr_next     = 1'b0;
          binary_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    status.frame_count = FCW'(count_next);
    status.frame_done  = done_next;
    status.cr_seen     = cr_next;
    status.binary_mode = binary_next;
    status.restarted   = restart;
  end

endmodule

/* design/dual_mode_frame_receiver.sv */
// top level of the dual mode frame receiver
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-----------
//  s_axis   | in  | rx_byte, read_index                         | req_type
//  m_axis   | out | read_data, frame_count, frame_done, cr_seen,| -
//           |     | binary_mode, restarted, zero fill           |
//
// one item per cycle sustained while the sink takes results; each item is held in the
// input register and its result is then registered into the output register
// the buffer read is a registered memory port read on the same edge
// rst clears frame state and both valid flags; the buffer keeps its contents
// a stalled result holds while the input register still takes one more item
module dual_mode_frame_receiver #(
  parameter int BUF_DEPTH = dmfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] rx_byte, [15:8] read_index
  input  logic [dmfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [dmfr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data, [16:8] frame_count, [17] frame_done, [18] cr_seen,
  // [19] binary_mode, [20] restarted, [23:21] zero
  output logic [dmfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int DW    = dmfr_pkg::DATA_W;
  localparam int PAD_W = dmfr_pkg::OUT_TDATA_W - DW - $bits(dmfr_pkg::status_t);

  logic              in_valid;
  dmfr_pkg::req_t    in_req;
  logic [DW-1:0]     in_byte;
  logic [DW-1:0]     in_index;
  logic              out_valid;
  dmfr_pkg::status_t out_status;
  logic              rd_sel;

  logic              advance;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data;
  logic [DW-1:0]     rd_data;
  dmfr_pkg::status_t status;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign rd_en         = advance && (in_req == dmfr_pkg::REQ_READ) &&
                         (32'(in_index) < BUF_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req   <= dmfr_pkg::req_t'(s_axis_tuser);
      in_byte  <= s_axis_tdata[DW-1:0];
      in_index <= s_axis_tdata[2*DW-1:DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status;
      rd_sel     <= rd_en;
    end
  end

  dmfr_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .req     (in_req),
    .rx_byte (in_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .status  (status)
  );

  dmfr_buffer #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(in_index)),
    .rd_data (rd_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}},
                          out_status.restarted,
                          out_status.binary_mode,
                          out_status.cr_seen,
                          out_status.frame_done,
                          out_status.frame_count,
                          rd_sel ? rd_data : {DW{1'b0}}};

endmodule

/* design/dmfr_checker.sv */
// port-level checks for the dual mode frame receiver, bound to the top level
`include "dual_mode_frame_receiver_macros.svh"

module dmfr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dmfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  `DMFR_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !m_axis_tvalid, "result valid right after reset")
  `DMFR_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `DMFR_ASSERT(a_done_clears_cr, m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[18]), "frame done with cr still pending")
  `DMFR_ASSERT(a_binary_no_cr, m_axis_tvalid |-> !(m_axis_tdata[19] && m_axis_tdata[18]), "cr pending in a binary frame")
  `DMFR_ASSERT(a_restart_empties, m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[16:8] == '0 && !m_axis_tdata[17] && !m_axis_tdata[19], "restart left frame state behind")

endmodule

bind dual_mode_frame_receiver dmfr_checker u_dmfr_checker (.*);

/* sim/dmfr_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the frame receiver: mirrors the frame state and compares each result
module dmfr_result_checker #(
  parameter int DEPTH = dmfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // [7:0] rx_byte, [15:8] read_index
  input  logic [dmfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [dmfr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data, [16:8] frame_count, [17] frame_done, [18] cr_seen,
  // [19] binary_mode, [20] restarted
  input  logic [dmfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                               fail_count,
  output int                               pending
);
  import dmfr_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic [COUNT_OUT_W-1:0] frame_count;
    logic                   frame_done;
    logic                   cr_seen;
    logic                   binary_mode;
    logic                   restarted;
  } rx_status_t;

  logic [DATA_W-1:0]      mirror_buf [DEPTH];
  logic [COUNT_OUT_W-1:0] held_count;
  logic                   held_done;
  logic                   held_cr;
  logic                   held_binary;
  logic [LEN_W-1:0]       frame_len;
  rx_status_t             status_q [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    held_count  = '0;
    held_done   = 1'b0;
    held_cr     = 1'b0;
    held_binary = 1'b0;
    frame_len   = '0;
  end

  function automatic void clear_frame();
    held_count  = '0;
    held_done   = 1'b0;
    held_cr     = 1'b0;
    held_binary = 1'b0;
  endfunction

  function automatic void keep_byte(input logic [COUNT_OUT_W-1:0] at,
                                    input logic [DATA_W-1:0] b);
    if (at < DEPTH) mirror_buf[at] = b;
  endfunction

  // returns 1 when the byte makes the frame start over
  function automatic logic absorb_byte(input logic [DATA_W-1:0] b);
    if (held_done) clear_frame();
    if (held_count == 0) begin
      held_binary = (b == BINARY_MARK);
      held_cr     = 1'b0;
    end
    if (held_binary) begin
      keep_byte(held_count, b);
      held_count = held_count + 1'b1;
      if (held_count >= LEN_MIN_COUNT) begin
        frame_len = {1'b0, mirror_buf[LEN_HI_IDX], mirror_buf[LEN_HI_IDX + 1]}
                    + LEN_W'(LEN_ADJ);
        // overflow wins over the length match
        if (held_count > DEPTH - 1) begin
          clear_frame();
          return 1'b1;
        end
        if (LEN_W'(held_count) == frame_len) held_done = 1'b1;
      end
      return 1'b0;
    end
    if (held_cr) begin
      if (b != CHAR_LF) begin
        clear_frame();
        return 1'b1;
      end
      // lf is stored but not counted, dropped when past the end
      keep_byte(held_count, b);
      held_cr   = 1'b0;
      held_done = 1'b1;
      return 1'b0;
    end
    keep_byte(held_count, b);
    held_count = held_count + 1'b1;
    if (b == CHAR_CR) begin
      held_cr = 1'b1;
      return 1'b0;
    end
    if (held_count > DEPTH - 1) begin
      clear_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rx_status_t predict_status(input logic [IN_TUSER_W-1:0] kind,
                                                input logic [IN_TDATA_W-1:0] payload);
    rx_status_t r;
    logic [DATA_W-1:0] idx;
    r   = '0;
    idx = payload[2*DATA_W-1:DATA_W];
    case (req_t'(kind))
      REQ_BYTE:    r.restarted = absorb_byte(payload[DATA_W-1:0]);
      REQ_READ: begin
        if (idx < DEPTH) r.read_data = mirror_buf[idx];
      end
      REQ_RELEASE: clear_frame();
      default: ;
    endcase
    r.frame_count = held_count;
    r.frame_done  = held_done;
    r.cr_seen     = held_cr;
    r.binary_mode = held_binary;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rx_status_t seen;
    rx_status_t want;
    if (rst) begin
      clear_frame();
      frame_len = '0;
      status_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.read_data   = m_axis_tdata[7:0];
        seen.frame_count = m_axis_tdata[16:8];
        seen.frame_done  = m_axis_tdata[17];
        seen.cr_seen     = m_axis_tdata[18];
        seen.binary_mode = m_axis_tdata[19];
        seen.restarted   = m_axis_tdata[20];
        if (status_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result at %0t: tdata %06h", $realtime, m_axis_tdata);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (seen.read_data !== want.read_data || seen.frame_count !== want.frame_count ||
              seen.frame_done !== want.frame_done || seen.cr_seen !== want.cr_seen ||
              seen.binary_mode !== want.binary_mode || seen.restarted !== want.restarted) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("mismatch at %0t: expected data %02h count %0d done %b cr %b bin %b rst %b",
                       $realtime, want.read_data, want.frame_count, want.frame_done,
                       want.cr_seen, want.binary_mode, want.restarted);
              $display("                 actual data %02h count %0d done %b cr %b bin %b rst %b",
                       seen.read_data, seen.frame_count, seen.frame_done,
                       seen.cr_seen, seen.binary_mode, seen.restarted);
            end
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        status_q.push_back(predict_status(s_axis_tuser, s_axis_tdata));
    end
    pending = status_q.size();
  end

endmodule

/* sim/dual_mode_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// testbench top for the frame receiver: clock, reset, stimulus, sink stalls and verdict
module dual_mode_frame_receiver_tb;
  import dmfr_pkg::*;

  localparam logic [IN_TUSER_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int ITEM_TARGET  = 1550;
  localparam int MAX_WAIT     = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 5;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int   fail_count;
  int   pending;
  logic quiet = 1'b0;
  logic reads_ok = 1'b0;
  logic byte_taken = 1'b0;
  logic result_taken = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   sink_hold = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  dual_mode_frame_receiver #(
    .BUF_DEPTH(BUF_DEPTH_DEF)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  dmfr_result_checker #(
    .DEPTH(BUF_DEPTH_DEF)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // handshakes as seen just before each rising edge
  always @(posedge clk) begin
    byte_taken   <= s_axis_tvalid && s_axis_tready;
    result_taken <= m_axis_tvalid && m_axis_tready;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: outside quiet stretches, after each taken result, stall for a drawn number of cycles
  always @(negedge clk) begin : sink
    int stall;
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
    end else if (result_taken && !quiet) begin
      stall = $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        sink_hold     <= stall - 1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_byte_except(input logic [DATA_W-1:0] no_a,
                                                         input logic [DATA_W-1:0] no_b);
    logic [DATA_W-1:0] b;
    do b = DATA_W'($urandom_range(0, 255)); while (b == no_a || b == no_b);
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [IN_TUSER_W-1:0] kind, input logic [DATA_W-1:0] b,
                           input logic [DATA_W-1:0] idx);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {idx, b};
    do @(negedge clk); while (!byte_taken);
    items_sent++;
  endtask

  task automatic read_entry(input logic [DATA_W-1:0] idx);
    send_item(REQ_READ, DATA_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic release_frame();
    send_item(REQ_RELEASE, DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
  endtask

  // a received byte, now and then preceded by a buffer read
  task automatic frame_byte(input logic [DATA_W-1:0] b);
    if (reads_ok && $urandom_range(0, 15) == 0) read_entry(DATA_W'($urandom_range(0, 255)));
    send_item(REQ_BYTE, b, DATA_W'($urandom_range(0, 255)));
  endtask

  // len content bytes, then cr and lf, or cr and a wrong byte when broken
  task automatic text_line(input int len, input logic broken);
    for (int i = 0; i < len; i++)
      frame_byte(i == 0 ? pick_byte_except(CHAR_CR, BINARY_MARK)
                        : pick_byte_except(CHAR_CR, CHAR_CR));
    frame_byte(CHAR_CR);
    frame_byte(broken ? pick_byte_except(CHAR_LF, CHAR_LF) : CHAR_LF);
  endtask

  // long declared lengths stop at the buffer depth, where the frame overflows
  task automatic binary_frame(input logic [DATA_W-1:0] len_hi, input logic [DATA_W-1:0] len_lo);
    int total;
    total = (int'(len_hi) << DATA_W) + int'(len_lo) + LEN_ADJ;
    if (total > BUF_DEPTH_DEF) total = BUF_DEPTH_DEF;
    frame_byte(BINARY_MARK);
    frame_byte(DATA_W'($urandom_range(0, 255)));
    frame_byte(len_hi);
    frame_byte(len_lo);
    for (int i = LEN_MIN_COUNT; i < total; i++) frame_byte(DATA_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int seq;
    int pick;
    logic rare;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one full-length line writes every entry; its lf falls past the end
    text_line(BUF_DEPTH_DEF - 1, 1'b0);
    reads_ok = 1'b1;

    read_entry('0);
    read_entry('1);
    frame_byte(CHAR_CR);
    frame_byte('0);
    binary_frame('0, '0);
    frame_byte(BINARY_MARK);
    release_frame();
    send_item(REQ_UNKNOWN, '1, '1);
    frame_byte('1);
    frame_byte(CHAR_CR);
    frame_byte(CHAR_LF);
    release_frame();
    frame_byte('0);
    send_item(REQ_RELEASE, '1, '1);

    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick  = (seq < 2) ? seq : $urandom_range(2, 99);
      rare  = ($urandom_range(0, 39) == 0);
      if (pick == 0) begin
        binary_frame(DATA_W'($urandom_range(1, 255)), DATA_W'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        text_line(BUF_DEPTH_DEF, 1'b0);
      end else if (pick < 32) begin
        text_line(rare ? $urandom_range(240, BUF_DEPTH_DEF) : $urandom_range(0, 12), 1'b0);
      end else if (pick < 57) begin
        binary_frame(rare ? DATA_W'($urandom_range(0, 255)) : '0,
                     rare ? DATA_W'($urandom_range(0, 255)) : DATA_W'($urandom_range(0, 20)));
      end else if (pick < 65) begin
        text_line($urandom_range(0, 8), 1'b1);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) read_entry(DATA_W'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        release_frame();
      end else if (pick < 90) begin
        send_item(REQ_UNKNOWN, DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) frame_byte(DATA_W'($urandom_range(0, 255)));
      end
      seq++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
